[design/wts_pkg.sv]
// weekly time switch package: command and status types, codes, week-time constants
// no dependencies
`default_nettype none

package wts_pkg;

    localparam int TIME_W = 14;
    localparam int CNT_W  = 5;
    localparam int OUT_CH = 4;

    localparam logic [TIME_W-1:0] MIN_PER_DAY  = 14'd1440;
    localparam logic [TIME_W-1:0] MIN_PER_HOUR = 14'd60;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TIME = 1'b1;

    localparam logic [1:0] CFG_RADIATOR    = 2'd0;
    localparam logic [1:0] CFG_FLOOR       = 2'd1;
    localparam logic [1:0] CFG_CIRCULATION = 2'd2;
    localparam logic [1:0] CFG_SHOWER      = 2'd3;

    typedef struct packed {
        logic second_tick;
        logic minute_tick;
        logic hour_tick;
    } t_ticks;

    typedef struct packed {
        logic              is_time;
        logic [1:0]        channel;
        logic [3:0]        entry;
        logic [TIME_W-1:0] on_time;
        logic [TIME_W-1:0] off_time;
        logic [TIME_W-1:0] now;
        t_ticks            ticks;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

[design/weekly_time_switch.sv]
// weekly time switch top level: front end, command queue, table walker
// depends on wts_pkg, wts_front, wts_queue, wts_back
// load item: queued, then written to the table when the idle walker pops it, no result
// time item: popped by the idle walker, which visits each channel in S_CHAN, scans its windows
// in S_CHECK and registers the result in S_DONE; one table read per cycle sets the scan rate
// reset clears entry counts, last time fields, queue and result valid; the table is not cleared
`default_nettype none

module weekly_time_switch
    import wts_pkg::*;
#(
    parameter int CHANNELS = 4,
    parameter int ENTRIES_PER_CHANNEL = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [4:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_kind,
    input  wire logic [1:0]  i_channel,
    input  wire logic [3:0]  i_entry,
    input  wire logic [13:0] i_on_time,
    input  wire logic [13:0] i_off_time,
    input  wire logic [2:0]  i_weekday,
    input  wire logic [4:0]  i_hour,
    input  wire logic [5:0]  i_minute,
    input  wire logic [5:0]  i_second,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_radiator_normal,
    output logic             o_floor_normal,
    output logic             o_circulation_on,
    output logic             o_shower_active,
    output logic             o_second_tick,
    output logic             o_minute_tick,
    output logic             o_hour_tick
);

    t_q_stat           q_stat;
    logic              push;
    logic              pop;
    t_cmd              push_cmd;
    t_cmd              pop_cmd;
    logic [OUT_CH-1:0] active;
    t_ticks            ticks;

    wts_front #(
        .CHANNELS            (CHANNELS),
        .ENTRIES_PER_CHANNEL (ENTRIES_PER_CHANNEL)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_kind     (i_kind),
        .i_channel  (i_channel),
        .i_entry    (i_entry),
        .i_on_time  (i_on_time),
        .i_off_time (i_off_time),
        .i_weekday  (i_weekday),
        .i_hour     (i_hour),
        .i_minute   (i_minute),
        .i_second   (i_second),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    wts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_data  (pop_cmd),
        .o_stat  (q_stat)
    );

    wts_back #(
        .CHANNELS            (CHANNELS),
        .ENTRIES_PER_CHANNEL (ENTRIES_PER_CHANNEL)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_stat    (q_stat),
        .i_cmd       (pop_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_active    (active),
        .o_ticks     (ticks)
    );

    assign o_radiator_normal = active[0];
    assign o_floor_normal    = active[1];
    assign o_circulation_on  = active[2];
    assign o_shower_active   = active[3];
    assign o_second_tick     = ticks.second_tick;
    assign o_minute_tick     = ticks.minute_tick;
    assign o_hour_tick       = ticks.hour_tick;

endmodule

`default_nettype wire

[design/wts_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module wts_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[design/wts_front.sv]
// front end: accepts items, drops out-of-range loads, forms week-time and change ticks
// depends on wts_pkg
`default_nettype none

module wts_front
    import wts_pkg::*;
#(
    parameter int CHANNELS = 4,
    parameter int ENTRIES_PER_CHANNEL = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_kind,
    input  wire logic [1:0]  i_channel,
    input  wire logic [3:0]  i_entry,
    input  wire logic [13:0] i_on_time,
    input  wire logic [13:0] i_off_time,
    input  wire logic [2:0]  i_weekday,
    input  wire logic [4:0]  i_hour,
    input  wire logic [5:0]  i_minute,
    input  wire logic [5:0]  i_second,
    input  wire t_q_stat     i_q_stat,
    output logic             o_push,
    output t_cmd             o_cmd
);

    logic [5:0] r_last_second, n_last_second;
    logic [5:0] r_last_minute, n_last_minute;
    logic [4:0] r_last_hour,   n_last_hour;
    logic       accept;
    logic       in_range;

    assign o_in_ready = !i_q_stat.full;
    assign accept     = i_in_valid && o_in_ready;
    assign in_range   = (32'(i_channel) < CHANNELS) && (32'(i_entry) < ENTRIES_PER_CHANNEL);
    assign o_push     = accept && ((i_kind == KIND_TIME) || in_range);

    always_comb begin
        o_cmd.is_time  = (i_kind == KIND_TIME);
        o_cmd.channel  = i_channel;
        o_cmd.entry    = i_entry;
        o_cmd.on_time  = i_on_time;
        o_cmd.off_time = i_off_time;
        o_cmd.now      = TIME_W'(i_weekday) * MIN_PER_DAY
                       + TIME_W'(i_hour) * MIN_PER_HOUR
                       + TIME_W'(i_minute);
        o_cmd.ticks.second_tick = (i_second != r_last_second);
        o_cmd.ticks.minute_tick = (i_minute != r_last_minute);
        o_cmd.ticks.hour_tick   = (i_hour != r_last_hour);
    end

    always_comb begin
        n_last_second = r_last_second;
        n_last_minute = r_last_minute;
        n_last_hour   = r_last_hour;
        if (accept && (i_kind == KIND_TIME)) begin
            n_last_second = i_second;
            n_last_minute = i_minute;
            n_last_hour   = i_hour;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_second <= '0;
            r_last_minute <= '0;
            r_last_hour   <= '0;
        end else begin
            r_last_second <= n_last_second;
            r_last_minute <= n_last_minute;
            r_last_hour   <= n_last_hour;
        end
    end

endmodule

`default_nettype wire

[design/wts_queue.sv]
// two-entry command queue between front end and table walker
// depends on wts_pkg
`default_nettype none

module wts_queue
    import wts_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    input  wire logic i_pop,
    output t_cmd      o_data,
    output t_q_stat   o_stat
);

    localparam int QDEPTH = 2;

    t_cmd       r_slot [QDEPTH];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;

    assign o_stat.full  = (r_count == 2'(QDEPTH));
    assign o_stat.empty = (r_count == 2'd0);
    assign o_data       = r_slot[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = !r_wptr;
        end
        if (i_pop) begin
            n_rptr = !r_rptr;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

[design/wts_back.sv]
// back end: entry count registers, table writes and per-channel table walk, result register
// depends on wts_pkg and wts_ram
`default_nettype none

module wts_back
    import wts_pkg::*;
#(
    parameter int CHANNELS = 4,
    parameter int ENTRIES_PER_CHANNEL = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [4:0]  i_cfg_data,
    input  wire t_q_stat     i_q_stat,
    input  wire t_cmd        i_cmd,
    output logic             o_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [OUT_CH-1:0] o_active,
    output t_ticks           o_ticks
);

    localparam int EPC    = ENTRIES_PER_CHANNEL;
    localparam int DEPTH  = CHANNELS * EPC;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = $clog2(EPC + 1);
    localparam int ACT_CH = (CHANNELS < OUT_CH) ? CHANNELS : OUT_CH;
    localparam int CHW    = (ACT_CH > 1) ? $clog2(ACT_CH) : 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHAN  = 4'b0010,
        S_CHECK = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt [OUT_CH];
    logic [TIME_W-1:0]  r_now, n_now;
    t_ticks             r_ticks, n_ticks;
    logic [CHW-1:0]     r_ch, n_ch;
    logic [AW-1:0]      r_base, n_base;
    logic [CW-1:0]      r_ent, n_ent;
    logic [OUT_CH-1:0]  r_act, n_act;
    logic               r_out_valid, n_out_valid;
    logic [OUT_CH-1:0]  r_out_act, n_out_act;
    t_ticks             r_out_ticks, n_out_ticks;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [2*TIME_W-1:0]  ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [2*TIME_W-1:0]  ram_rdata;
    logic [TIME_W-1:0]    win_start;
    logic [TIME_W-1:0]    win_end;
    logic [CNT_W-1:0]     cnt_sel;
    logic [CW-1:0]        lim;
    logic [CW-1:0]        ent_next;
    logic                 last_ch;

    wts_ram #(
        .WIDTH (2 * TIME_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign win_start = ram_rdata[2*TIME_W-1:TIME_W];
    assign win_end   = ram_rdata[TIME_W-1:0];
    assign cnt_sel   = r_cnt[2'(r_ch)];
    assign lim       = (32'(cnt_sel) > EPC) ? CW'(EPC) : CW'(cnt_sel);
    assign ent_next  = r_ent + CW'(1);
    assign last_ch   = (r_ch == CHW'(ACT_CH - 1));

    assign o_pop     = (r_state == S_IDLE) && !i_q_stat.empty;
    assign ram_we    = o_pop && !i_cmd.is_time;
    assign ram_waddr = AW'(i_cmd.channel) * AW'(EPC) + AW'(i_cmd.entry);
    assign ram_wdata = {i_cmd.on_time, i_cmd.off_time};

    always_comb begin
        n_state     = r_state;
        n_now       = r_now;
        n_ticks     = r_ticks;
        n_ch        = r_ch;
        n_base      = r_base;
        n_ent       = r_ent;
        n_act       = r_act;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_act   = r_out_act;
        n_out_ticks = r_out_ticks;
        ram_raddr   = r_base;
        case (r_state)
            S_IDLE: begin
                if (o_pop && i_cmd.is_time) begin
                    n_now   = i_cmd.now;
                    n_ticks = i_cmd.ticks;
                    n_ch    = '0;
                    n_base  = '0;
                    n_act   = '0;
                    n_state = S_CHAN;
                end
            end
            S_CHAN: begin
                ram_raddr = r_base;
                n_ent     = '0;
                if (lim == '0) begin
                    n_act[2'(r_ch)] = 1'b0;
                    if (last_ch) begin
                        n_state = S_DONE;
                    end else begin
                        n_ch   = r_ch + CHW'(1);
                        n_base = r_base + AW'(EPC);
                    end
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                ram_raddr = r_base + AW'(ent_next);
                if ((r_now <= win_end) || (ent_next >= lim)) begin
                    n_act[2'(r_ch)] = (r_now <= win_end) && (r_now > win_start);
                    if (last_ch) begin
                        n_state = S_DONE;
                    end else begin
                        n_ch    = r_ch + CHW'(1);
                        n_base  = r_base + AW'(EPC);
                        n_state = S_CHAN;
                    end
                end else begin
                    n_ent = ent_next;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_act   = r_act;
                    n_out_ticks = r_ticks;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < OUT_CH; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RADIATOR:    r_cnt[0] <= i_cfg_data;
                CFG_FLOOR:       r_cnt[1] <= i_cfg_data;
                CFG_CIRCULATION: r_cnt[2] <= i_cfg_data;
                CFG_SHOWER:      r_cnt[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now       <= n_now;
        r_ticks     <= n_ticks;
        r_ch        <= n_ch;
        r_base      <= n_base;
        r_ent       <= n_ent;
        r_act       <= n_act;
        r_out_act   <= n_out_act;
        r_out_ticks <= n_out_ticks;
    end

    assign o_out_valid = r_out_valid;
    assign o_active    = r_out_act;
    assign o_ticks     = r_out_ticks;

endmodule

`default_nettype wire

[design/wts_checker.sv]
// port-level checker for weekly_time_switch and its bind
// depends on weekly_time_switch port list
`default_nettype none

module wts_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_radiator_normal,
    input wire logic        o_floor_normal,
    input wire logic        o_circulation_on,
    input wire logic        o_shower_active,
    input wire logic        o_second_tick,
    input wire logic        o_minute_tick,
    input wire logic        o_hour_tick
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable({o_radiator_normal, o_floor_normal,
            o_circulation_on, o_shower_active, o_second_tick, o_minute_tick, o_hour_tick}))
        else $error("result item changed while stalled");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");

endmodule

bind weekly_time_switch wts_checker u_wts_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_radiator_normal (o_radiator_normal),
    .o_floor_normal    (o_floor_normal),
    .o_circulation_on  (o_circulation_on),
    .o_shower_active   (o_shower_active),
    .o_second_tick     (o_second_tick),
    .o_minute_tick     (o_minute_tick),
    .o_hour_tick       (o_hour_tick)
);

`default_nettype wire
